[src/quaternion_to_euler_top_macros.svh]
// assertion macros used by the checker of this block
`ifndef QUATERNION_TO_EULER_TOP_MACROS_SVH
`define QUATERNION_TO_EULER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define QTE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quaternion_to_euler check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define QTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quaternion_to_euler check failed");

`endif

[src/qte_pkg.sv]
`default_nettype none
package qte_pkg;

    localparam int QUAT_W = 16;
    localparam int PROD_W = 32;
    localparam int SUM_W = 34;
    localparam int SP_W = 29;
    localparam int SQ_W = 57;
    localparam int ROOT_STAGES = 29;
    localparam int CORDIC_W = 36;
    localparam int ANG_W = 32;

    localparam logic signed [SUM_W-1:0] Q_ONE = SUM_W'(64'sd1 <<< 28);
    localparam logic [ANG_W-1:0] HALF_PI = 32'h4000_0000;
    localparam logic [ANG_W-1:0] NEG_HALF_PI = 32'hC000_0000;
    localparam logic [ANG_W-1:0] PI_ANGLE = 32'h8000_0000;

    localparam logic [ANG_W-1:0] ATAN_TABLE [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [SUM_W-1:0] sr;
        logic signed [SUM_W-1:0] cr;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] cy;
        logic signed [SP_W-1:0]  sp;
        logic                    sat_pos;
        logic                    sat_neg;
    } qte_sums_t;

endpackage
`default_nettype wire

[src/qte_products.sv]
`default_nettype none
module qte_products (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [15:0]            quat_w,
    input  wire logic signed [15:0]            quat_x,
    input  wire logic signed [15:0]            quat_y,
    input  wire logic signed [15:0]            quat_z,
    output logic                               out_valid,
    output qte_pkg::qte_sums_t                 sums
);
    import qte_pkg::*;

    logic signed [PROD_W-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg;
    logic signed [PROD_W-1:0] zx_reg, wz_reg, xy_reg, zz_reg;
    logic                     v1_reg, v2_reg;
    qte_sums_t                sums_reg, sums_next;
    logic signed [SUM_W-1:0]  sp_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= quat_w * quat_x;
            yz_reg <= quat_y * quat_z;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            wy_reg <= quat_w * quat_y;
            zx_reg <= quat_z * quat_x;
            wz_reg <= quat_w * quat_z;
            xy_reg <= quat_x * quat_y;
            zz_reg <= quat_z * quat_z;
            sums_reg <= sums_next;
        end
    end

    always_comb
    begin
        sp_full = (SUM_W'(wy_reg) - SUM_W'(zx_reg)) <<< 1;
        sums_next.sr = (SUM_W'(wx_reg) + SUM_W'(yz_reg)) <<< 1;
        sums_next.cr = Q_ONE - ((SUM_W'(xx_reg) + SUM_W'(yy_reg)) <<< 1);
        sums_next.sy = (SUM_W'(wz_reg) + SUM_W'(xy_reg)) <<< 1;
        sums_next.cy = Q_ONE - ((SUM_W'(yy_reg) + SUM_W'(zz_reg)) <<< 1);
        sums_next.sp = sp_full[SP_W-1:0];
        sums_next.sat_pos = (sp_full >= Q_ONE);
        sums_next.sat_neg = (sp_full <= -Q_ONE);
    end

    assign out_valid = v2_reg;
    assign sums = sums_reg;
endmodule
`default_nettype wire

[src/qte_sqrt.sv]
`default_nettype none
module qte_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire qte_pkg::qte_sums_t            in_sums,
    output logic                               out_valid,
    output qte_pkg::qte_sums_t                 out_sums,
    output logic [qte_pkg::SP_W-1:0]           root
);
    import qte_pkg::*;

    localparam int DEPTH = ROOT_STAGES + 2;

    logic            valid_reg [DEPTH];
    qte_sums_t       pay_reg [DEPTH];
    logic [SQ_W-1:0] sq_reg;
    logic [SQ_W-1:0] rem_reg [ROOT_STAGES+1];
    logic [SQ_W-1:0] res_reg [ROOT_STAGES+1];
    logic signed [2*SP_W-1:0] sq_full;

    assign sq_full = in_sums.sp * in_sums.sp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg[0] <= in_sums;
            for (int i = 1; i < DEPTH; i++)
                pay_reg[i] <= pay_reg[i-1];
            sq_reg <= sq_full[SQ_W-1:0];
            rem_reg[0] <= (SQ_W'(1) << 56) - sq_reg;
            res_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < ROOT_STAGES; j++)
    begin : g_root
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (56 - 2*j);
        logic [SQ_W-1:0] trial;
        assign trial = res_reg[j] + BIT;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[j] >= trial)
                begin
                    rem_reg[j+1] <= rem_reg[j] - trial;
                    res_reg[j+1] <= (res_reg[j] >> 1) + BIT;
                end
                else
                begin
                    rem_reg[j+1] <= rem_reg[j];
                    res_reg[j+1] <= res_reg[j] >> 1;
                end
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign out_sums = pay_reg[DEPTH-1];
    assign root = res_reg[ROOT_STAGES][SP_W-1:0];
endmodule
`default_nettype wire

[src/qte_cordic.sv]
`default_nettype none
module qte_cordic #(
    parameter int ANGLE_BITS = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic signed [qte_pkg::CORDIC_W-1:0] vec_y,
    input  wire logic signed [qte_pkg::CORDIC_W-1:0] vec_x,
    input  wire logic                                force_en,
    input  wire logic [qte_pkg::ANG_W-1:0]           force_angle,
    output logic                                     out_valid,
    output logic [ANGLE_BITS-1:0]                    angle
);
    import qte_pkg::*;

    localparam logic [32:0] HALF_LSB = (33'd1 << (32 - ANGLE_BITS)) >> 1;

    logic                       valid_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] x_reg [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg [CORDIC_STEPS+1];
    logic [ANG_W-1:0]           a_reg [CORDIC_STEPS+1];
    logic                       f_reg [CORDIC_STEPS+1];
    logic [ANG_W-1:0]           fa_reg [CORDIC_STEPS+1];
    logic                       out_valid_reg;
    logic [ANGLE_BITS-1:0]      angle_reg;
    logic [ANG_W-1:0]           final_angle;
    logic [ANG_W-1:0]           rounded;
    logic                       is_zero;

    assign is_zero = (vec_x == '0) && (vec_y == '0);
    assign final_angle = f_reg[CORDIC_STEPS] ? fa_reg[CORDIC_STEPS] : a_reg[CORDIC_STEPS];
    assign rounded = final_angle + HALF_LSB[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= CORDIC_STEPS; i++)
                valid_reg[i] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i <= CORDIC_STEPS; i++)
                valid_reg[i] <= valid_reg[i-1];
            out_valid_reg <= valid_reg[CORDIC_STEPS];
        end
    end

    // pre-rotation into the right half plane, force flag capture and output angle rounding
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg[0] <= force_en || is_zero;
            fa_reg[0] <= force_en ? force_angle : '0;
            if (vec_x < 0)
            begin
                x_reg[0] <= -vec_x;
                y_reg[0] <= -vec_y;
                a_reg[0] <= PI_ANGLE;
            end
            else
            begin
                x_reg[0] <= vec_x;
                y_reg[0] <= vec_y;
                a_reg[0] <= '0;
            end
            angle_reg <= rounded[31 -: ANGLE_BITS];
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [CORDIC_W-1:0] xs, ys;
        assign xs = x_reg[i] >>> i;
        assign ys = y_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                f_reg[i+1] <= f_reg[i];
                fa_reg[i+1] <= fa_reg[i];
                if (y_reg[i] < 0)
                begin
                    x_reg[i+1] <= x_reg[i] - ys;
                    y_reg[i+1] <= y_reg[i] + xs;
                    a_reg[i+1] <= a_reg[i] - ATAN_TABLE[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + ys;
                    y_reg[i+1] <= y_reg[i] - xs;
                    a_reg[i+1] <= a_reg[i] + ATAN_TABLE[i];
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign angle = angle_reg;
endmodule
`default_nettype wire

[src/quaternion_to_euler_top.sv]
`default_nettype none
// Converts one unit quaternion (w, x, y, z, signed Q2.14) per request into Z-Y-X Euler
// angles: roll, pitch and yaw as signed binary angles with LSB pi / 2^(ANGLE_BITS-1).
// A request is taken every clock cycle while the output is not stalled; each request passes
// through the product and sum registers, the 29-stage square root that feeds the pitch
// vector and the vectoring CORDIC pipelines. The whole pipeline stalls together
// while a finished result waits on the output; pitch saturates to +-pi/2 once the
// sine term reaches one in magnitude.
module quaternion_to_euler_top #(
    parameter int ANGLE_BITS = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z
    input  wire logic [63:0]                         s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // roll_angle, pitch_angle, yaw_angle, zero pad
    output logic [((3*ANGLE_BITS+7)/8)*8-1:0]        m_axis_tdata
);
    import qte_pkg::*;

    localparam int OUT_W = ((3*ANGLE_BITS+7)/8)*8;

    logic                       en;
    logic                       prod_valid, root_valid;
    qte_sums_t                  prod_sums, root_sums;
    logic [SP_W-1:0]            root;
    logic                       roll_valid, pitch_valid, yaw_valid;
    logic [ANGLE_BITS-1:0]      roll_angle, pitch_angle, yaw_angle;
    logic [ANG_W-1:0]           sat_angle;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    qte_products u_products (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .quat_w    (s_axis_tdata[15:0]),
        .quat_x    (s_axis_tdata[31:16]),
        .quat_y    (s_axis_tdata[47:32]),
        .quat_z    (s_axis_tdata[63:48]),
        .out_valid (prod_valid),
        .sums      (prod_sums)
    );

    qte_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (prod_valid),
        .in_sums   (prod_sums),
        .out_valid (root_valid),
        .out_sums  (root_sums),
        .root      (root)
    );

    assign sat_angle = root_sums.sat_pos ? HALF_PI : NEG_HALF_PI;

    qte_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (root_valid),
        .vec_y       (CORDIC_W'(root_sums.sr)),
        .vec_x       (CORDIC_W'(root_sums.cr)),
        .force_en    (1'b0),
        .force_angle ('0),
        .out_valid   (roll_valid),
        .angle       (roll_angle)
    );

    qte_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (root_valid),
        .vec_y       (CORDIC_W'(root_sums.sp)),
        .vec_x       (CORDIC_W'({1'b0, root})),
        .force_en    (root_sums.sat_pos || root_sums.sat_neg),
        .force_angle (sat_angle),
        .out_valid   (pitch_valid),
        .angle       (pitch_angle)
    );

    qte_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (root_valid),
        .vec_y       (CORDIC_W'(root_sums.sy)),
        .vec_x       (CORDIC_W'(root_sums.cy)),
        .force_en    (1'b0),
        .force_angle ('0),
        .out_valid   (yaw_valid),
        .angle       (yaw_angle)
    );

    assign m_axis_tvalid = roll_valid && pitch_valid && yaw_valid;
    assign m_axis_tdata = OUT_W'({yaw_angle, pitch_angle, roll_angle});
endmodule
`default_nettype wire

[src/qte_checker.sv]
`default_nettype none
`include "quaternion_to_euler_top_macros.svh"
module qte_checker #(
    parameter int ANGLE_BITS = 16
) (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 s_axis_tvalid,
    input wire logic                                 s_axis_tready,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [((3*ANGLE_BITS+7)/8)*8-1:0]    m_axis_tdata
);
    localparam logic signed [ANGLE_BITS-1:0] PMAX = ANGLE_BITS'(64'sd1 <<< (ANGLE_BITS-2));

    logic signed [ANGLE_BITS-1:0] pitch;
    logic                         in_req;

    assign pitch = m_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS];
    assign in_req = s_axis_tvalid && s_axis_tready;

    `QTE_ASSERT_NOW(a_ready_follows_out, 1'b1, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    `QTE_ASSERT_NOW(a_pitch_range, m_axis_tvalid, (pitch <= PMAX) && (pitch >= -PMAX))
    `QTE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `QTE_ASSERT_NEXT(a_no_take_on_stall, m_axis_tvalid && !m_axis_tready, $past(!in_req))
endmodule

bind quaternion_to_euler_top qte_checker #(.ANGLE_BITS(ANGLE_BITS)) u_qte_checker (.*);
`default_nettype wire
